### hdl/address_vector_table_defines.svh
// assertion macros for the address vector table
`ifndef ADDRESS_VECTOR_TABLE_DEFINES_SVH
`define ADDRESS_VECTOR_TABLE_DEFINES_SVH

// same-cycle implication
`define AVT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AVT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/avt_pkg.sv
// shared types, constants and helpers of the address vector table
package avt_pkg;

   localparam int ENTRIES  = 64;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   localparam int OP_W     = 3;
   localparam int FAMILY_W = 16;
   localparam int ADDR_W   = 32;
   localparam int PORT_W   = 16;
   localparam int HANDLE_W = 64;
   localparam int ENTRY_W  = FAMILY_W + ADDR_W + PORT_W;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;
   localparam int CTX_W    = 5;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_ONLY    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONTEXT_BITS = 2'd1;

   localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd1;
   localparam logic [OP_W-1:0] OP_FIND    = 3'd2;
   localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPARE = 3'd4;

   localparam logic [STATUS_W-1:0] STS_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] STS_BAD_FAMILY = 3'd1;
   localparam logic [STATUS_W-1:0] STS_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] STS_RANGE      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND  = 3'd4;

   localparam logic [FAMILY_W-1:0] FAMILY_IPV4 = 16'd2;
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = 7'd127;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic [ENTRY_W-1:0] key;
      logic               fam_ok;
      logic [IDX_W-1:0]   idx_a;
      logic               over_a;
      logic [IDX_W-1:0]   idx_b;
      logic               over_b;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [FAMILY_W-1:0] family;
      logic [ADDR_W-1:0]   ip_addr;
      logic [PORT_W-1:0]   port;
      logic                same;
      logic [COUNT_W-1:0]  count;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

### hdl/avt_front.sv
// front end: accepts commands, masks handles and classifies them
module avt_front (
   input  logic                         start,
   output logic                         busy,
   input  logic [avt_pkg::OP_W-1:0]     req_operation,
   input  logic [avt_pkg::FAMILY_W-1:0] req_family,
   input  logic [avt_pkg::ADDR_W-1:0]   req_ip_addr,
   input  logic [avt_pkg::PORT_W-1:0]   req_port,
   input  logic [avt_pkg::HANDLE_W-1:0] req_handle_a,
   input  logic [avt_pkg::HANDLE_W-1:0] req_handle_b,
   input  logic                         req_batch_last,
   input  logic [avt_pkg::CTX_W-1:0]    context_bits,
   input  avt_pkg::q_stat_type          q_stat,
   output logic                         push,
   output avt_pkg::cmd_type             cmd
);
   import avt_pkg::*;

   logic [HANDLE_W-1:0] mask;
   logic [HANDLE_W-1:0] sel_a;
   logic [HANDLE_W-1:0] sel_b;

   // shifting ones right keeps the low (64 - context_bits) handle bits
   assign mask  = {HANDLE_W{1'b1}} >> context_bits;
   // remove works on the raw handle
   assign sel_a = (req_operation == OP_REMOVE) ? req_handle_a : (req_handle_a & mask);
   assign sel_b = req_handle_b & mask;

   assign busy = q_stat.full;
   assign push = start && !q_stat.full;

   always_comb begin
      cmd.op     = req_operation;
      cmd.key    = {req_family, req_ip_addr, req_port};
      cmd.fam_ok = (req_family == FAMILY_IPV4);
      cmd.idx_a  = sel_a[IDX_W-1:0];
      cmd.over_a = |sel_a[HANDLE_W-1:IDX_W];
      cmd.idx_b  = sel_b[IDX_W-1:0];
      cmd.over_b = |sel_b[HANDLE_W-1:IDX_W];
      cmd.last   = req_batch_last;
   end

endmodule

### hdl/avt_queue.sv
// two-entry command queue between front and back end
module avt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  avt_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output avt_pkg::cmd_type    pop_cmd,
   output avt_pkg::q_stat_type q_stat
);
   import avt_pkg::*;

   cmd_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign pop_cmd      = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

### hdl/avt_back.sv
// back end: entry store, scan sequencer and result register
`include "address_vector_table_defines.svh"

module avt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                read_only,
   input  avt_pkg::q_stat_type q_stat,
   input  avt_pkg::cmd_type    q_cmd,
   output logic                pop,
   output logic                rsp_strobe,
   output avt_pkg::rsp_type    rsp
);
   import avt_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_LOOK    = 3'd1;
   localparam logic [2:0] ST_CMP_B   = 3'd2;
   localparam logic [2:0] ST_CMP_END = 3'd3;
   localparam logic [2:0] ST_SCAN    = 3'd4;

   logic [ENTRY_W-1:0] entry_store_ff [ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;

   logic [2:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] batch_ff, batch_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [ENTRY_W-1:0] hit_data_ff, hit_data_in;
   logic [ENTRY_W-1:0] data_a_ff, data_a_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic               rd_en;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [COUNT_W-1:0] count_next;
   logic               in_range_a;
   logic               in_range_b;
   logic               match_find;
   logic               match_full;

   function automatic rsp_type make_rsp(
      input logic [STATUS_W-1:0] status,
      input logic [IDX_W-1:0]    idx,
      input logic [ENTRY_W-1:0]  entry,
      input logic                same,
      input logic [COUNT_W-1:0]  count
   );
      rsp_type r;
      r.status  = status;
      r.index   = INDEX_W'(idx);
      r.family  = entry[ENTRY_W-1 -: FAMILY_W];
      r.ip_addr = entry[PORT_W +: ADDR_W];
      r.port    = entry[PORT_W-1:0];
      r.same    = same;
      r.count   = count;
      return r;
   endfunction

   assign count_next = count_up(batch_ff);
   assign in_range_a = !q_cmd.over_a && (CNT_W'(q_cmd.idx_a) < fill_ff);
   assign in_range_b = !q_cmd.over_b && (CNT_W'(q_cmd.idx_b) < fill_ff);
   assign match_find = (rd_data_ff[ADDR_W+PORT_W-1:0] == cmd_ff.key[ADDR_W+PORT_W-1:0]);
   assign match_full = (rd_data_ff == cmd_ff.key);
   assign wr_addr    = fill_ff[IDX_W-1:0];

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      fill_in       = fill_ff;
      batch_in      = batch_ff;
      valid_in      = valid_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_data_in   = hit_data_ff;
      data_a_in     = data_a_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               unique case (q_cmd.op)
                  OP_INSERT: begin
                     if (read_only) begin
                        if (!q_cmd.fam_ok) begin
                           rsp_in        = make_rsp(STS_BAD_FAMILY, '0, '0, 1'b0, batch_ff);
                           rsp_strobe_in = 1'b1;
                           if (q_cmd.last) begin
                              batch_in = '0;
                           end
                        end else begin
                           state_in = ST_SCAN;
                           scan_in  = '0;
                           hit_in   = 1'b0;
                        end
                     end else if (fill_ff == CNT_W'(ENTRIES)) begin
                        rsp_in        = make_rsp(STS_FULL, '0, '0, 1'b0, batch_ff);
                        rsp_strobe_in = 1'b1;
                        if (q_cmd.last) begin
                           batch_in = '0;
                        end
                     end else if (!q_cmd.fam_ok) begin
                        rsp_in        = make_rsp(STS_BAD_FAMILY, '0, '0, 1'b0, batch_ff);
                        rsp_strobe_in = 1'b1;
                        if (q_cmd.last) begin
                           batch_in = '0;
                        end
                     end else begin
                        wr_en             = 1'b1;
                        valid_in[wr_addr] = 1'b1;
                        fill_in           = fill_ff + CNT_W'(1);
                        rsp_in            = make_rsp(STS_OK, wr_addr, q_cmd.key, 1'b0,
                                                     count_next);
                        rsp_strobe_in     = 1'b1;
                        batch_in          = q_cmd.last ? '0 : count_next;
                     end
                  end
                  OP_LOOKUP: begin
                     if (in_range_a) begin
                        rd_en    = 1'b1;
                        rd_addr  = q_cmd.idx_a;
                        state_in = ST_LOOK;
                     end else begin
                        rsp_in        = make_rsp(STS_RANGE, '0, '0, 1'b0, batch_ff);
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  OP_FIND: begin
                     state_in = ST_SCAN;
                     scan_in  = '0;
                     hit_in   = 1'b0;
                  end
                  OP_REMOVE: begin
                     if (in_range_a) begin
                        valid_in[q_cmd.idx_a] = 1'b0;
                        rsp_in = make_rsp(STS_OK, q_cmd.idx_a, '0, 1'b0, batch_ff);
                     end else begin
                        rsp_in = make_rsp(STS_RANGE, '0, '0, 1'b0, batch_ff);
                     end
                     rsp_strobe_in = 1'b1;
                  end
                  OP_COMPARE: begin
                     if (in_range_a && in_range_b) begin
                        rd_en    = 1'b1;
                        rd_addr  = q_cmd.idx_a;
                        state_in = ST_CMP_B;
                     end else begin
                        rsp_in        = make_rsp(STS_RANGE, '0, '0, 1'b0, batch_ff);
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in        = make_rsp(STS_OK, '0, '0, 1'b0, batch_ff);
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOOK: begin
            rsp_in        = make_rsp(STS_OK, cmd_ff.idx_a, rd_data_ff, 1'b0, batch_ff);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_CMP_B: begin
            rd_en     = 1'b1;
            rd_addr   = cmd_ff.idx_b;
            data_a_in = rd_data_ff;
            state_in  = ST_CMP_END;
         end
         ST_CMP_END: begin
            rsp_in        = make_rsp(STS_OK, '0, '0, data_a_ff == rd_data_ff, batch_ff);
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            // issue one read a cycle, compare the data of the previous one
            if (scan_ff != fill_ff) begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff[IDX_W-1:0];
               rd_idx_in  = scan_ff[IDX_W-1:0];
               rd_pend_in = 1'b1;
               scan_in    = scan_ff + CNT_W'(1);
            end
            if (rd_pend_ff) begin
               if (cmd_ff.op == OP_FIND) begin
                  if (match_find && !hit_ff) begin
                     hit_in      = 1'b1;
                     hit_idx_in  = rd_idx_ff;
                     hit_data_in = rd_data_ff;
                  end
               end else if (match_full) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = rd_idx_ff;
                  hit_data_in = rd_data_ff;
                  batch_in    = count_next;
               end
            end else if (scan_ff == fill_ff) begin
               if (hit_ff) begin
                  rsp_in = make_rsp(STS_OK, hit_idx_ff, hit_data_ff, 1'b0, batch_ff);
               end else begin
                  rsp_in = make_rsp(STS_NOT_FOUND, '0, '0, 1'b0, batch_ff);
               end
               rsp_strobe_in = 1'b1;
               if (cmd_ff.op == OP_INSERT && cmd_ff.last) begin
                  batch_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         batch_ff      <= '0;
         valid_ff      <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         batch_ff      <= batch_in;
         valid_ff      <= valid_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_data_ff <= hit_data_in;
      data_a_ff   <= data_a_in;
      rsp_ff      <= rsp_in;
   end

   // entry store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_store_ff[wr_addr] <= q_cmd.key;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_store_ff[rd_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp        = rsp_ff;

   `AVT_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(ENTRIES),
                   "fill count above capacity")
   `AVT_ASSERT_NXT(a_fill_step, clock, reset, wr_en, fill_ff == $past(fill_ff) + CNT_W'(1),
                   "append did not advance fill count")
   `AVT_ASSERT_IMP(a_pop_idle, clock, reset, pop, state_ff == ST_IDLE,
                   "queue popped while a command is in progress")
   `AVT_ASSERT_IMP(a_scan_bound, clock, reset, state_ff == ST_SCAN, scan_ff <= fill_ff,
                   "scan ran past fill count")

endmodule

### hdl/address_vector_table.sv
// top level of the address vector table: config registers and block wiring
//
//   channel   direction  handshake              transaction
//   request   in         start & !busy          one command with its operands
//   response  out        rsp_strobe (1 cycle)   one result per command
//   csr       in         csr_valid & csr_ready  one register write
//
// with the back end idle the strobe comes from the idle state for insert, remove,
// errors and unknown codes; lookup reads the entry first, compare reads both entries in
// turn; find and read-only insert scan the filled entries on the single store read port
// a two-entry queue decouples acceptance from execution; busy is high while it is full
// reset is synchronous and clears the valid bits, fill count, batch count and config
// csr_ready is always high; the response side cannot stall
module address_vector_table (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [avt_pkg::OP_W-1:0]        req_operation,
   input  logic [avt_pkg::FAMILY_W-1:0]    req_family,
   input  logic [avt_pkg::ADDR_W-1:0]      req_ip_addr,
   input  logic [avt_pkg::PORT_W-1:0]      req_port,
   input  logic [avt_pkg::HANDLE_W-1:0]    req_handle_a,
   input  logic [avt_pkg::HANDLE_W-1:0]    req_handle_b,
   input  logic                            req_batch_last,
   output logic                            rsp_strobe,
   output logic [avt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [avt_pkg::INDEX_W-1:0]     rsp_index,
   output logic [avt_pkg::FAMILY_W-1:0]    rsp_out_family,
   output logic [avt_pkg::ADDR_W-1:0]      rsp_out_ip_addr,
   output logic [avt_pkg::PORT_W-1:0]      rsp_out_port,
   output logic                            rsp_same,
   output logic [avt_pkg::COUNT_W-1:0]     rsp_batch_success_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [avt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [avt_pkg::CSR_DATA_W-1:0]  csr_data
);
   import avt_pkg::*;

   logic             read_only_ff, read_only_in;
   logic [CTX_W-1:0] context_bits_ff, context_bits_in;

   q_stat_type q_stat;
   cmd_type    push_cmd;
   cmd_type    pop_cmd;
   logic       push;
   logic       pop;
   rsp_type    rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      read_only_in    = read_only_ff;
      context_bits_in = context_bits_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_READ_ONLY:    read_only_in    = csr_data[0];
            CSR_CONTEXT_BITS: context_bits_in = csr_data[CTX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_only_ff    <= 1'b0;
         context_bits_ff <= '0;
      end else begin
         read_only_ff    <= read_only_in;
         context_bits_ff <= context_bits_in;
      end
   end

   avt_front u_front (
      .start          (start),
      .busy           (busy),
      .req_operation  (req_operation),
      .req_family     (req_family),
      .req_ip_addr    (req_ip_addr),
      .req_port       (req_port),
      .req_handle_a   (req_handle_a),
      .req_handle_b   (req_handle_b),
      .req_batch_last (req_batch_last),
      .context_bits   (context_bits_ff),
      .q_stat         (q_stat),
      .push           (push),
      .cmd            (push_cmd)
   );

   avt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .q_stat   (q_stat)
   );

   avt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .read_only  (read_only_ff),
      .q_stat     (q_stat),
      .q_cmd      (pop_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign rsp_status              = rsp.status;
   assign rsp_index               = rsp.index;
   assign rsp_out_family          = rsp.family;
   assign rsp_out_ip_addr         = rsp.ip_addr;
   assign rsp_out_port            = rsp.port;
   assign rsp_same                = rsp.same;
   assign rsp_batch_success_count = rsp.count;

endmodule
